// File: src/per_pixel_attack_release_smoother_assert.svh
// ----------------------------------------------------------------------------
// per_pixel_attack_release_smoother_assert
// assertion macros for the smoother; clk and rst_n come from the module scope
// ----------------------------------------------------------------------------
`ifndef PER_PIXEL_ATTACK_RELEASE_SMOOTHER_ASSERT_SVH
`define PER_PIXEL_ATTACK_RELEASE_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define ARS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ars_pkg.sv
// ----------------------------------------------------------------------------
// ars_pkg
// shared widths, register codes and types of the attack/release smoother
// ----------------------------------------------------------------------------
package ars_pkg;

    // pixel store geometry
    localparam int IDX_W       = 12;
    localparam int PIXEL_COUNT = 1 << IDX_W;

    // payload widths
    localparam int VAL_W  = 16;
    localparam int GAIN_W = 17;
    localparam int PROD_W = VAL_W + GAIN_W;

    // gain constants, q1.16
    localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'h10000;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd21810;

    // register bus
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index codes, taken from paddr[2]
    localparam logic REG_RISE_GAIN = 1'b0;
    localparam logic REG_FALL_GAIN = 1'b1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [GAIN_W-1:0] gain_t;
    typedef logic [PROD_W-1:0] prod_t;

endpackage

// File: src/ars_intf.sv
// ----------------------------------------------------------------------------
// ars_intf
// valid/ready channels carrying pixels into and out of the smoother
// ----------------------------------------------------------------------------
interface ars_pix_in_if;

    logic          valid;
    logic          ready;
    ars_pkg::idx_t pixel_index;
    ars_pkg::val_t in_hue;
    ars_pkg::val_t in_saturation;
    ars_pkg::val_t in_value;

    modport source
    (
        output valid, pixel_index, in_hue, in_saturation, in_value,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_index, in_hue, in_saturation, in_value,
        output ready
    );

endinterface

interface ars_pix_out_if;

    logic          valid;
    logic          ready;
    ars_pkg::val_t out_hue;
    ars_pkg::val_t out_saturation;
    ars_pkg::val_t out_value;

    modport source
    (
        output valid, out_hue, out_saturation, out_value,
        input  ready
    );

    modport sink
    (
        input  valid, out_hue, out_saturation, out_value,
        output ready
    );

endinterface

// File: src/per_pixel_attack_release_smoother.sv
// ----------------------------------------------------------------------------
// per_pixel_attack_release_smoother
// per-pixel brightness smoother with separate rise and fall gains
// ----------------------------------------------------------------------------
//  channel     dir  handshake             payload
//  pixel_in    in   valid/ready           pixel_index, in_hue, in_saturation,
//                                          in_value
//  pixel_out   out  valid/ready           out_hue, out_saturation, out_value
//  apb         in   psel/penable/pready   paddr, pwdata, prdata (rise, fall gain)
//
//  one pixel per clock sustained unless stalled; after its transfer in a result
//  passes store read, gain multiply, and update and write back before it leaves.
//  the store has one read and one write port, so its read-modify-write loop
//  takes a pixel every clock; a pixel that repeats back to back is served by
//  forwarding from the update stage and from the last write.
//  after reset a clearing pass zeroes the 4096-entry store, one entry per
//  cycle, during which no pixel is taken; gain writes go on.
//  a stall on pixel_out freezes the whole pipe, the output register holds.
// ----------------------------------------------------------------------------
`include "per_pixel_attack_release_smoother_assert.svh"

module per_pixel_attack_release_smoother
(
    input  logic                                clk,
    input  logic                                rst_n,
    ars_pix_in_if.sink                          pixel_in,
    ars_pix_out_if.source                       pixel_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ars_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ars_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ars_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    // gain registers
    ars_pkg::gain_t rise_gain_reg;
    ars_pkg::gain_t fall_gain_reg;

    // clearing pass
    ars_pkg::idx_t  clr_cnt_reg;
    logic           clr_done_reg;

    // store and its read data
    ars_pkg::val_t  store_mem [ars_pkg::PIXEL_COUNT];
    ars_pkg::val_t  rdata_reg;
    logic           mem_we;
    ars_pkg::idx_t  mem_waddr;
    ars_pkg::val_t  mem_wdata;

    // last committed write, for forwarding
    logic           lw_valid_reg;
    ars_pkg::idx_t  lw_idx_reg;
    ars_pkg::val_t  lw_value_reg;

    // stage 1: forwarded read, multiply
    logic           s1_valid_reg;
    ars_pkg::idx_t  s1_idx_reg;
    ars_pkg::val_t  s1_hue_reg;
    ars_pkg::val_t  s1_sat_reg;
    ars_pkg::val_t  s1_target_reg;
    ars_pkg::val_t  s1_last;
    logic           s1_up;
    logic           s1_eq;
    ars_pkg::val_t  s1_diff;
    ars_pkg::gain_t s1_gain_sel;
    ars_pkg::gain_t s1_gain_eff;
    ars_pkg::prod_t s1_prod;

    // stage 2: step, clamp, write back
    logic           s2_valid_reg;
    ars_pkg::idx_t  s2_idx_reg;
    ars_pkg::val_t  s2_hue_reg;
    ars_pkg::val_t  s2_sat_reg;
    ars_pkg::val_t  s2_target_reg;
    ars_pkg::val_t  s2_last_reg;
    ars_pkg::val_t  s2_diff_reg;
    logic           s2_up_reg;
    logic           s2_eq_reg;
    ars_pkg::prod_t s2_prod_reg;
    ars_pkg::gain_t s2_step_hi;
    ars_pkg::gain_t s2_step;
    ars_pkg::val_t  s2_next;

    // output register
    logic           out_valid_reg;
    ars_pkg::val_t  out_hue_reg;
    ars_pkg::val_t  out_sat_reg;
    ars_pkg::val_t  out_value_reg;

    logic           adv;
    logic           in_xfer;
    logic           cfg_wr;

    // pipe moves when the output slot is free or being drained
    assign adv     = !out_valid_reg || pixel_out.ready;
    assign in_xfer = pixel_in.valid && pixel_in.ready;
    assign pixel_in.ready = adv && clr_done_reg;

    // register port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ars_pkg::REG_FALL_GAIN)
                  ? {{(ars_pkg::APB_DATA_W - ars_pkg::GAIN_W){1'b0}}, fall_gain_reg}
                  : {{(ars_pkg::APB_DATA_W - ars_pkg::GAIN_W){1'b0}}, rise_gain_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_gain_reg <= ars_pkg::GAIN_RESET;
            fall_gain_reg <= ars_pkg::GAIN_RESET;
        end
        else if (cfg_wr && pready)
        begin
            case (paddr[2])
                ars_pkg::REG_RISE_GAIN: rise_gain_reg <= pwdata[ars_pkg::GAIN_W-1:0];
                ars_pkg::REG_FALL_GAIN: fall_gain_reg <= pwdata[ars_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ars_pkg::idx_t'(ars_pkg::PIXEL_COUNT - 1))
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // store write port: zeros while clearing, else the updated value
    assign mem_we    = !clr_done_reg || (s2_valid_reg && adv);
    assign mem_waddr = clr_done_reg ? s2_idx_reg : clr_cnt_reg;
    assign mem_wdata = clr_done_reg ? s2_next : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
    end

    // store read port, held while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rdata_reg <= store_mem[pixel_in.pixel_index];
        end
    end

    // last write tracker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (s2_valid_reg && adv)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && adv)
        begin
            lw_idx_reg   <= s2_idx_reg;
            lw_value_reg <= s2_next;
        end
    end

    // stage 1 transfer in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg    <= pixel_in.pixel_index;
            s1_hue_reg    <= pixel_in.in_hue;
            s1_sat_reg    <= pixel_in.in_saturation;
            s1_target_reg <= pixel_in.in_value;
        end
    end

    // forward the newest value of this pixel, then difference and gain product
    always_comb
    begin
        if (s2_valid_reg && (s2_idx_reg == s1_idx_reg))
        begin
            s1_last = s2_next;
        end
        else if (lw_valid_reg && (lw_idx_reg == s1_idx_reg))
        begin
            s1_last = lw_value_reg;
        end
        else
        begin
            s1_last = rdata_reg;
        end

        s1_up       = s1_target_reg > s1_last;
        s1_eq       = s1_target_reg == s1_last;
        s1_diff     = s1_up ? (s1_target_reg - s1_last) : (s1_last - s1_target_reg);
        s1_gain_sel = s1_up ? rise_gain_reg : fall_gain_reg;
        s1_gain_eff = (s1_gain_sel > ars_pkg::GAIN_ONE) ? ars_pkg::GAIN_ONE : s1_gain_sel;
        s1_prod     = ars_pkg::PROD_W'(s1_diff) * ars_pkg::PROD_W'(s1_gain_eff);
    end

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_idx_reg    <= s1_idx_reg;
            s2_hue_reg    <= s1_hue_reg;
            s2_sat_reg    <= s1_sat_reg;
            s2_target_reg <= s1_target_reg;
            s2_last_reg   <= s1_last;
            s2_diff_reg   <= s1_diff;
            s2_up_reg     <= s1_up;
            s2_eq_reg     <= s1_eq;
            s2_prod_reg   <= s1_prod;
        end
    end

    // step of at least one lsb, no overshoot
    always_comb
    begin
        s2_step_hi = s2_prod_reg[ars_pkg::PROD_W-1:ars_pkg::VAL_W];
        s2_step    = (s2_step_hi == '0) ? ars_pkg::gain_t'(1) : s2_step_hi;
        if (s2_eq_reg)
        begin
            s2_next = s2_last_reg;
        end
        else if (s2_step >= ars_pkg::gain_t'(s2_diff_reg))
        begin
            s2_next = s2_target_reg;
        end
        else if (s2_up_reg)
        begin
            s2_next = s2_last_reg + s2_step[ars_pkg::VAL_W-1:0];
        end
        else
        begin
            s2_next = s2_last_reg - s2_step[ars_pkg::VAL_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            out_hue_reg   <= s2_hue_reg;
            out_sat_reg   <= s2_sat_reg;
            out_value_reg <= s2_next;
        end
    end

    assign pixel_out.valid          = out_valid_reg;
    assign pixel_out.out_hue        = out_hue_reg;
    assign pixel_out.out_saturation = out_sat_reg;
    assign pixel_out.out_value      = out_value_reg;

    // checks
    `ARS_ASSERT_IMP(a_no_pixel_while_clearing, s1_valid_reg || s2_valid_reg, clr_done_reg,
        "pixel in flight before store clearing finished")
    `ARS_ASSERT_IMP(a_step_within_range, s2_valid_reg && s2_up_reg,
        (s2_next > s2_last_reg) && (s2_next <= s2_target_reg),
        "rising step left the range between stored value and target")
    `ARS_ASSERT_IMP(a_fall_within_range, s2_valid_reg && !s2_up_reg && !s2_eq_reg,
        (s2_next < s2_last_reg) && (s2_next >= s2_target_reg),
        "falling step left the range between stored value and target")

endmodule
